// ===== hw/rtl/nsm_pkg.sv =====
// Shared constants, types and helpers for the neighbour sum match finder.
`timescale 1ns / 1ps

package nsm_pkg;

    localparam int MAX_DIM   = 64;
    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int POS_W     = 2 * DIM_W;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int VALUE_W   = 32;
    localparam int SUM_W     = VALUE_W + 4;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_IDX_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] dividend;
        logic [DIM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] quotient;
        logic [DIM_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic               clear;
        logic               add;
        logic               center;
        logic [VALUE_W-1:0] data;
    } acc_req_t;

    typedef struct packed {
        logic               equal;
        logic [VALUE_W-1:0] center;
    } acc_rsp_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
        return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col));
    endfunction

endpackage

// ===== hw/rtl/neighbour_sum_match_finder_unit.sv =====
// Top level of the neighbour sum match finder: sequencer, element store, result register.
`timescale 1ns / 1ps
//
// Input channel s_*: s_func = 0 loads s_element_value into the next raster cell,
// s_func = 1 fetches the next cell whose value equals the sum of its eight
// neighbours (cells outside the matrix count as zero). A load after a fetch
// starts a new matrix. Only fetches give a result on m_*.
// Counts come from cfg_wen/cfg_index/cfg_wdata (0 rows, 1 columns), written idle.
// A fetch handles each scanned cell in steps: a bound check, nine reads through
// the single store read port, one drain and one compare; when the scan runs out,
// a final bound check ends it, and the result is then posted.
// After a count change, and for a fetch after an exhausted scan, the raster
// position is first converted to row and column in the bit-serial divider.
// A load right after a fetch restarts at the origin and skips this.
// s_ready is high only while the sequencer is idle. A posted result waits in
// the output register; further loads are taken meanwhile, and a fetch stalls
// at its result until m_ready frees the register.
// Reset (aresetn low, synchronous) zeroes the positions, sets both counts to 1
// and empties the output register; the store is not cleared.
//
module neighbour_sum_match_finder_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  logic [nsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nsm_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_func,
    input  logic signed [31:0]             s_element_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_found,
    output logic [5:0]                     m_match_row,
    output logic [5:0]                     m_match_col,
    output logic signed [31:0]             m_match_value,
    output logic                           m_done_res
);

    localparam int DIM_W   = nsm_pkg::DIM_W;
    localparam int IDX_W   = nsm_pkg::IDX_W;
    localparam int POS_W   = nsm_pkg::POS_W;
    localparam int ADDR_W  = nsm_pkg::ADDR_W;
    localparam int DEPTH   = nsm_pkg::DEPTH;
    localparam int VALUE_W = nsm_pkg::VALUE_W;
    localparam int CFG_W   = nsm_pkg::CFG_W;
    localparam int OUT_W   = nsm_pkg::OUT_IDX_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_LAST  = 3'd4;
    localparam logic [2:0] ST_CMP   = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    localparam logic [3:0] TAP_CENTER = 4'd4;
    localparam logic [3:0] TAP_LAST   = 4'd8;

    logic [2:0]         state_reg, state_next;
    logic [CFG_W-1:0]   row_count_reg, row_count_next;
    logic [CFG_W-1:0]   col_count_reg, col_count_next;
    logic [POS_W-1:0]   load_pos_reg, load_pos_next;
    logic [POS_W-1:0]   scan_pos_reg, scan_pos_next;
    logic [DIM_W-1:0]   load_r_reg, load_r_next, load_c_reg, load_c_next;
    logic [DIM_W-1:0]   scan_r_reg, scan_r_next, scan_c_reg, scan_c_next;
    logic               load_stale_reg, load_stale_next;
    logic               scan_stale_reg, scan_stale_next;
    logic               last_fetch_reg, last_fetch_next;
    logic               op_reg, op_next;
    logic [VALUE_W-1:0] item_value_reg, item_value_next;
    logic [3:0]         tap_k_reg, tap_k_next;
    logic               tap_vld_reg, tap_vld_next;
    logic               tap_ctr_reg, tap_ctr_next;
    logic [VALUE_W-1:0] rd_data_reg;

    logic               res_found_reg, res_found_next;
    logic [OUT_W-1:0]   res_row_reg, res_row_next, res_col_reg, res_col_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;
    logic               res_done_reg, res_done_next;

    logic               m_valid_reg, m_valid_next;
    logic               m_found_reg, m_found_next;
    logic [OUT_W-1:0]   m_row_reg, m_row_next, m_col_reg, m_col_next;
    logic [VALUE_W-1:0] m_value_reg, m_value_next;
    logic               m_done_reg, m_done_next;

    logic [DIM_W-1:0]   rows_eff, cols_eff;
    logic [POS_W-1:0]   total;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;

    logic               ld_go;
    logic [POS_W-1:0]   ld_pos;
    logic [DIM_W-1:0]   ld_r, ld_c;
    logic [VALUE_W-1:0] ld_val;

    logic [1:0]         tap_dr, tap_dc;
    logic [DIM_W:0]     nbr_r, nbr_c;
    logic               nbr_in;

    nsm_pkg::div_req_t  div_req;
    nsm_pkg::div_rsp_t  div_rsp;
    nsm_pkg::acc_req_t  acc_req;
    nsm_pkg::acc_rsp_t  acc_rsp;

    logic [VALUE_W-1:0] mem [0:DEPTH-1];

    function automatic logic [2*DIM_W-1:0] adv_pos(input logic [DIM_W-1:0] r,
                                                  input logic [DIM_W-1:0] c,
                                                  input logic [DIM_W-1:0] cols);
        logic [2*DIM_W-1:0] res;
        if (c + DIM_W'(1) == cols) begin
            res = {r + DIM_W'(1), {DIM_W{1'b0}}};
        end else begin
            res = {r, c + DIM_W'(1)};
        end
        return res;
    endfunction

    assign rows_eff = nsm_pkg::clamp_dim(row_count_reg);
    assign cols_eff = nsm_pkg::clamp_dim(col_count_reg);
    assign total    = POS_W'(rows_eff) * POS_W'(cols_eff);

    // tap k walks the 3x3 window in raster order; codes 0/1/2 mean -1/0/+1
    always_comb begin
        case (tap_k_reg) inside
            [4'd0:4'd2]: tap_dr = 2'd0;
            [4'd3:4'd5]: tap_dr = 2'd1;
            default:     tap_dr = 2'd2;
        endcase
        case (tap_k_reg)
            4'd0, 4'd3, 4'd6: tap_dc = 2'd0;
            4'd1, 4'd4, 4'd7: tap_dc = 2'd1;
            default:          tap_dc = 2'd2;
        endcase
    end

    // -1 at the edge wraps to all ones, which fails the unsigned bound check
    assign nbr_r  = {1'b0, scan_r_reg} + (DIM_W + 1)'(tap_dr) - (DIM_W + 1)'(1);
    assign nbr_c  = {1'b0, scan_c_reg} + (DIM_W + 1)'(tap_dc) - (DIM_W + 1)'(1);
    assign nbr_in = (nbr_r < {1'b0, rows_eff}) && (nbr_c < {1'b0, cols_eff});

    assign rd_en   = (state_reg == ST_READ);
    assign rd_addr = nsm_pkg::cell_addr(nbr_r[IDX_W-1:0], nbr_c[IDX_W-1:0]);

    assign acc_req.clear  = (state_reg == ST_CHECK);
    assign acc_req.add    = tap_vld_reg && !tap_ctr_reg;
    assign acc_req.center = tap_vld_reg && tap_ctr_reg;
    assign acc_req.data   = rd_data_reg;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        row_count_next  = row_count_reg;
        col_count_next  = col_count_reg;
        load_pos_next   = load_pos_reg;
        scan_pos_next   = scan_pos_reg;
        load_r_next     = load_r_reg;
        load_c_next     = load_c_reg;
        scan_r_next     = scan_r_reg;
        scan_c_next     = scan_c_reg;
        load_stale_next = load_stale_reg;
        scan_stale_next = scan_stale_reg;
        last_fetch_next = last_fetch_reg;
        op_next         = op_reg;
        item_value_next = item_value_reg;
        tap_k_next      = tap_k_reg;
        tap_vld_next    = 1'b0;
        tap_ctr_next    = 1'b0;
        res_found_next  = res_found_reg;
        res_row_next    = res_row_reg;
        res_col_next    = res_col_reg;
        res_value_next  = res_value_reg;
        res_done_next   = res_done_reg;
        m_valid_next    = m_valid_reg;
        m_found_next    = m_found_reg;
        m_row_next      = m_row_reg;
        m_col_next      = m_col_reg;
        m_value_next    = m_value_reg;
        m_done_next     = m_done_reg;
        div_req.start    = 1'b0;
        div_req.dividend = load_pos_reg;
        div_req.divisor  = cols_eff;
        ld_go   = 1'b0;
        ld_pos  = load_pos_reg;
        ld_r    = load_r_reg;
        ld_c    = load_c_reg;
        ld_val  = item_value_reg;
        wr_en   = 1'b0;
        wr_addr = nsm_pkg::cell_addr(load_r_reg[IDX_W-1:0], load_c_reg[IDX_W-1:0]);
        wr_data = item_value_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next         = s_func;
                    item_value_next = s_element_value;
                    if (s_func == nsm_pkg::FUNC_LOAD) begin
                        if (last_fetch_reg) begin
                            // new matrix: both positions restart at the origin
                            last_fetch_next = 1'b0;
                            scan_pos_next   = '0;
                            scan_r_next     = '0;
                            scan_c_next     = '0;
                            scan_stale_next = 1'b0;
                            load_stale_next = 1'b0;
                            ld_go  = 1'b1;
                            ld_pos = '0;
                            ld_r   = '0;
                            ld_c   = '0;
                            ld_val = s_element_value;
                        end else if (load_stale_reg) begin
                            div_req.start    = 1'b1;
                            div_req.dividend = load_pos_reg;
                            state_next       = ST_DIV;
                        end else begin
                            ld_go  = 1'b1;
                            ld_val = s_element_value;
                        end
                    end else begin
                        last_fetch_next = 1'b1;
                        if (scan_stale_reg) begin
                            div_req.start    = 1'b1;
                            div_req.dividend = scan_pos_reg;
                            state_next       = ST_DIV;
                        end else begin
                            state_next = ST_CHECK;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    if (op_reg == nsm_pkg::FUNC_LOAD) begin
                        load_stale_next = 1'b0;
                        ld_go      = 1'b1;
                        ld_r       = DIM_W'(div_rsp.quotient);
                        ld_c       = div_rsp.remainder;
                        state_next = ST_IDLE;
                    end else begin
                        scan_r_next     = DIM_W'(div_rsp.quotient);
                        scan_c_next     = div_rsp.remainder;
                        scan_stale_next = 1'b0;
                        state_next      = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (scan_pos_reg < total) begin
                    tap_k_next = '0;
                    state_next = ST_READ;
                end else begin
                    res_found_next  = 1'b0;
                    res_row_next    = '0;
                    res_col_next    = '0;
                    res_value_next  = '0;
                    res_done_next   = 1'b1;
                    scan_pos_next   = total;
                    // row/column no longer track the clamped position
                    scan_stale_next = 1'b1;
                    state_next      = ST_EMIT;
                end
            end
            ST_READ: begin
                tap_vld_next = nbr_in;
                tap_ctr_next = (tap_k_reg == TAP_CENTER);
                tap_k_next   = tap_k_reg + 4'd1;
                if (tap_k_reg == TAP_LAST) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                scan_pos_next              = scan_pos_reg + POS_W'(1);
                {scan_r_next, scan_c_next} = adv_pos(scan_r_reg, scan_c_reg, cols_eff);
                if (acc_rsp.equal) begin
                    res_found_next = 1'b1;
                    res_row_next   = OUT_W'(scan_r_reg);
                    res_col_next   = OUT_W'(scan_c_reg);
                    res_value_next = acc_rsp.center;
                    res_done_next  = 1'b0;
                    state_next     = ST_EMIT;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_found_next = res_found_reg;
                    m_row_next   = res_row_reg;
                    m_col_next   = res_col_reg;
                    m_value_next = res_value_reg;
                    m_done_next  = res_done_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (ld_go) begin
            if (ld_pos < total) begin
                wr_en         = 1'b1;
                wr_addr       = nsm_pkg::cell_addr(ld_r[IDX_W-1:0], ld_c[IDX_W-1:0]);
                wr_data       = ld_val;
                load_pos_next = ld_pos + POS_W'(1);
                {load_r_next, load_c_next} = adv_pos(ld_r, ld_c, cols_eff);
            end else begin
                // loads past the last cell are dropped
                load_pos_next = ld_pos;
                load_r_next   = ld_r;
                load_c_next   = ld_c;
            end
        end

        if (cfg_wen) begin
            case (cfg_index)
                nsm_pkg::CFG_ROWS: begin
                    row_count_next  = cfg_wdata;
                    load_stale_next = 1'b1;
                    scan_stale_next = 1'b1;
                end
                nsm_pkg::CFG_COLS: begin
                    col_count_next  = cfg_wdata;
                    load_stale_next = 1'b1;
                    scan_stale_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            row_count_reg  <= CFG_W'(1);
            col_count_reg  <= CFG_W'(1);
            load_pos_reg   <= '0;
            scan_pos_reg   <= '0;
            load_r_reg     <= '0;
            load_c_reg     <= '0;
            scan_r_reg     <= '0;
            scan_c_reg     <= '0;
            load_stale_reg <= 1'b0;
            scan_stale_reg <= 1'b0;
            last_fetch_reg <= 1'b0;
            tap_k_reg      <= '0;
            tap_vld_reg    <= 1'b0;
            tap_ctr_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            row_count_reg  <= row_count_next;
            col_count_reg  <= col_count_next;
            load_pos_reg   <= load_pos_next;
            scan_pos_reg   <= scan_pos_next;
            load_r_reg     <= load_r_next;
            load_c_reg     <= load_c_next;
            scan_r_reg     <= scan_r_next;
            scan_c_reg     <= scan_c_next;
            load_stale_reg <= load_stale_next;
            scan_stale_reg <= scan_stale_next;
            last_fetch_reg <= last_fetch_next;
            tap_k_reg      <= tap_k_next;
            tap_vld_reg    <= tap_vld_next;
            tap_ctr_reg    <= tap_ctr_next;
            m_valid_reg    <= m_valid_next;
        end
        op_reg         <= op_next;
        item_value_reg <= item_value_next;
        res_found_reg  <= res_found_next;
        res_row_reg    <= res_row_next;
        res_col_reg    <= res_col_next;
        res_value_reg  <= res_value_next;
        res_done_reg   <= res_done_next;
        m_found_reg    <= m_found_next;
        m_row_reg      <= m_row_next;
        m_col_reg      <= m_col_next;
        m_value_reg    <= m_value_next;
        m_done_reg     <= m_done_next;
    end

    nsm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    nsm_acc u_acc (
        .aclk (aclk),
        .req  (acc_req),
        .rsp  (acc_rsp)
    );

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_match_row   = m_row_reg;
    assign m_match_col   = m_col_reg;
    assign m_match_value = $signed(m_value_reg);
    assign m_done_res    = m_done_reg;

`ifndef SYNTHESIS
    a_found_xor_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_found_reg && m_done_reg))
        else $error("result flags found and done both set");

    a_emit_posts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("emitted result did not reach the output register");

    a_fetch_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_func) |=> last_fetch_reg)
        else $error("accepted fetch did not set the fetch mark");

    a_cmp_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> ($past(state_reg) == ST_LAST))
        else $error("compare reached without draining the read pipe");

    a_match_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> (scan_r_reg < rows_eff && scan_c_reg < cols_eff))
        else $error("scanned cell outside the matrix");
`endif

endmodule

// ===== hw/rtl/nsm_div.sv =====
// Iterative restoring divider: raster position to row and column.
`timescale 1ns / 1ps

module nsm_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  nsm_pkg::div_req_t req,
    output nsm_pkg::div_rsp_t rsp
);

    localparam int POS_W = nsm_pkg::POS_W;
    localparam int DIM_W = nsm_pkg::DIM_W;
    localparam int CNT_W = $clog2(POS_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0] quo_reg, quo_next;
    logic [DIM_W-1:0] rem_reg, rem_next;
    logic [DIM_W-1:0] dvs_reg, dvs_next;
    logic [DIM_W:0]   shifted;
    logic [DIM_W:0]   diff;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[POS_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(POS_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so DIM_W bits hold it
            rem_next = fits ? diff[DIM_W-1:0] : shifted[DIM_W-1:0];
            quo_next = {quo_reg[POS_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== hw/rtl/nsm_acc.sv =====
// Shared accumulator and compare unit for the neighbour sum of one cell.
`timescale 1ns / 1ps

module nsm_acc (
    input  logic              aclk,
    input  nsm_pkg::acc_req_t req,
    output nsm_pkg::acc_rsp_t rsp
);

    localparam int VALUE_W = nsm_pkg::VALUE_W;
    localparam int SUM_W   = nsm_pkg::SUM_W;

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [VALUE_W-1:0]      center_reg, center_next;
    logic signed [SUM_W-1:0] data_ext;
    logic signed [SUM_W-1:0] center_ext;

    assign data_ext   = SUM_W'($signed(req.data));
    assign center_ext = SUM_W'($signed(center_reg));

    always_comb begin
        sum_next    = sum_reg;
        center_next = center_reg;
        if (req.clear) begin
            sum_next = '0;
        end else if (req.add) begin
            sum_next = sum_reg + data_ext;
        end
        if (req.center) begin
            center_next = req.data;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg    <= sum_next;
        center_reg <= center_next;
    end

    assign rsp.equal  = (sum_reg == center_ext);
    assign rsp.center = center_reg;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the neighbour sum match finder: raster loads, match fetches, counts.
`timescale 1ns / 1ps

module tb_top;

    localparam int VALUE_W   = nsm_pkg::VALUE_W;
    localparam int CFG_W     = nsm_pkg::CFG_W;
    localparam int CFG_IDX_W = nsm_pkg::CFG_IDX_W;
    localparam int MAX_DIM   = nsm_pkg::MAX_DIM;
    localparam int DEPTH     = nsm_pkg::DEPTH;

    localparam int CYCLE_LIMIT   = 10_000_000;
    localparam int RANDOM_ITEMS  = 750;
    localparam int SETTLE_CYCLES = 32;
    localparam int TAIL_CYCLES   = 200;

    typedef struct packed {
        logic               func;
        logic [VALUE_W-1:0] value;
    } finder_item_t;

    typedef struct packed {
        logic               found;
        logic [5:0]         row;
        logic [5:0]         col;
        logic [VALUE_W-1:0] value;
        logic               done;
    } scan_answer_t;

    typedef enum int {FILL_ZERO, FILL_SMALL, FILL_WIDE, FILL_EDGE} fill_style_t;
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 cfg_wen         = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index       = nsm_pkg::CFG_ROWS;
    logic [CFG_W-1:0]     cfg_wdata       = '0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic                 s_func          = nsm_pkg::FUNC_LOAD;
    logic signed [31:0]   s_element_value = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic                 m_found;
    logic [5:0]           m_match_row;
    logic [5:0]           m_match_col;
    logic signed [31:0]   m_match_value;
    logic                 m_done_res;

    neighbour_sum_match_finder_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wen         (cfg_wen),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_element_value (s_element_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_found         (m_found),
        .m_match_row     (m_match_row),
        .m_match_col     (m_match_col),
        .m_match_value   (m_match_value),
        .m_done_res      (m_done_res)
    );

    // predictor state
    logic [VALUE_W-1:0] elem_mem [0:DEPTH-1];
    logic [CFG_W-1:0]   rows_reg    = CFG_W'(1);
    logic [CFG_W-1:0]   cols_reg    = CFG_W'(1);
    int                 load_at     = 0;
    int                 scan_at     = 0;
    bit                 after_fetch = 1'b0;
    scan_answer_t       answer_q[$];

    // stimulus state
    finder_item_t       item_q[$];
    logic [VALUE_W-1:0] grid [0:MAX_DIM-1][0:MAX_DIM-1];
    bit                 written [0:DEPTH-1];
    int                 gen_load_at     = 0;
    bit                 gen_after_fetch = 1'b0;
    int                 gen_rows        = 1;
    int                 gen_cols        = 1;
    int                 queued          = 0;

    int       burst_left  = 1;
    int       gap_left    = 0;
    rx_mode_t rx_mode     = RX_OPEN;
    int       rx_left     = 0;
    int       rx_tick     = 0;
    int       cycle_count = 0;
    int       fail_count  = 0;
    int       n_loads     = 0;
    int       n_fetches   = 0;
    int       n_results   = 0;
    int       n_found     = 0;
    int       n_settings  = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic int dim_in_use(input logic [CFG_W-1:0] raw);
        if (raw == '0) return 1;
        if (int'(raw) > MAX_DIM) return MAX_DIM;
        return int'(raw);
    endfunction

    // cells outside the matrix read as zero
    function automatic longint stored_cell(input int r, input int c, input int nr, input int nc);
        longint v;
        v = 0;
        if (r >= 0 && c >= 0 && r < nr && c < nc) v = $signed(elem_mem[r * MAX_DIM + c]);
        return v;
    endfunction

    task automatic advance_finder(input logic func, input logic [VALUE_W-1:0] value);
        int           nr;
        int           nc;
        int           total;
        int           r;
        int           c;
        longint       ring;
        scan_answer_t ans;
        bit           hit;
        nr    = dim_in_use(rows_reg);
        nc    = dim_in_use(cols_reg);
        total = nr * nc;
        if (func == nsm_pkg::FUNC_LOAD) begin
            n_loads++;
            if (after_fetch) begin
                load_at     = 0;
                scan_at     = 0;
                after_fetch = 1'b0;
            end
            if (load_at < total) begin
                elem_mem[(load_at / nc) * MAX_DIM + load_at % nc] = value;
                load_at++;
            end
        end else begin
            n_fetches++;
            after_fetch = 1'b1;
            ans = '0;
            hit = 1'b0;
            while (!hit && scan_at < total) begin
                r    = scan_at / nc;
                c    = scan_at % nc;
                ring = 0;
                for (int dr = -1; dr <= 1; dr++)
                    for (int dc = -1; dc <= 1; dc++)
                        if (dr != 0 || dc != 0) ring += stored_cell(r + dr, c + dc, nr, nc);
                scan_at++;
                if (ring == stored_cell(r, c, nr, nc)) begin
                    hit       = 1'b1;
                    ans.found = 1'b1;
                    ans.row   = 6'(r);
                    ans.col   = 6'(c);
                    ans.value = elem_mem[r * MAX_DIM + c];
                end
            end
            if (!hit) begin
                scan_at  = total;
                ans.done = 1'b1;
            end
            answer_q.push_back(ans);
        end
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // ---------------- stimulus helpers ----------------

    task automatic push_load(input logic [VALUE_W-1:0] value);
        finder_item_t it;
        if (gen_after_fetch) begin
            gen_load_at     = 0;
            gen_after_fetch = 1'b0;
        end
        if (gen_load_at < gen_rows * gen_cols) begin
            written[(gen_load_at / gen_cols) * MAX_DIM + gen_load_at % gen_cols] = 1'b1;
            gen_load_at++;
        end
        it.func  = nsm_pkg::FUNC_LOAD;
        it.value = value;
        item_q.push_back(it);
        queued++;
    endtask

    function automatic bit matrix_ready();
        bit ok;
        ok = 1'b1;
        for (int r = 0; r < gen_rows; r++)
            for (int c = 0; c < gen_cols; c++)
                if (!written[r * MAX_DIM + c]) ok = 1'b0;
        return ok;
    endfunction

    // a fetch is only issued once every cell under the current counts holds a value
    task automatic push_fetch();
        finder_item_t it;
        if (!matrix_ready()) return;
        gen_after_fetch = 1'b1;
        it.func  = nsm_pkg::FUNC_FETCH;
        it.value = $urandom();
        item_q.push_back(it);
        queued++;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value(input fill_style_t style);
        logic [VALUE_W-1:0] v;
        case (style)
            FILL_ZERO:  v = '0;
            FILL_SMALL: v = (VALUE_W'($urandom_range(0, 6)) - VALUE_W'(3)) << 16;
            FILL_WIDE:  v = $urandom();
            default: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'h0000_0000;
                    3:       v = 32'hFFFF_FFFF;
                    default: v = 32'h0001_0000;
                endcase
            end
        endcase
        return v;
    endfunction

    // set a cell to its neighbour sum when that sum fits in 32 bits
    task automatic plant_cell(input int r, input int c, input int nr, input int nc);
        longint s;
        int     rr;
        int     cc;
        s = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                rr = r + dr;
                cc = c + dc;
                if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < nr && cc < nc)
                    s += $signed(grid[rr][cc]);
            end
        end
        if (s == longint'($signed(s[31:0]))) grid[r][c] = s[31:0];
    endtask

    task automatic fill_grid(input int nr, input int nc, input fill_style_t style);
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
                grid[r][c] = pick_value(style);
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
                if ($urandom_range(0, 3) == 0) plant_cell(r, c, nr, nc);
    endtask

    task automatic load_grid(input int nr, input int nc);
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
                push_load(grid[r][c]);
    endtask

    // sender drained and every answer back, then room for a trailing load
    task automatic wait_idle();
        do @(negedge aclk);
        while (item_q.size() != 0 || s_valid || answer_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        if (idx == nsm_pkg::CFG_ROWS) rows_reg = val;
        else cols_reg = val;
    endtask

    task automatic set_counts(input logic [CFG_W-1:0] raw_rows, input logic [CFG_W-1:0] raw_cols);
        wait_idle();
        write_reg(nsm_pkg::CFG_ROWS, raw_rows);
        write_reg(nsm_pkg::CFG_COLS, raw_cols);
        gen_rows = dim_in_use(raw_rows);
        gen_cols = dim_in_use(raw_cols);
        n_settings++;
    endtask

    // ---------------- driver ----------------

    always @(posedge aclk) begin : drive
        finder_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left != 0 || item_q.size() == 0) begin
                s_valid <= 1'b0;
                if (gap_left != 0) gap_left--;
            end else begin
                nxt = item_q.pop_front();
                s_valid         <= 1'b1;
                s_func          <= nxt.func;
                s_element_value <= nxt.value;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // result side stalls in modes of its own
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 160);
            end else begin
                rx_left--;
            end
            rx_tick++;
            case (rx_mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= (rx_tick % 4 == 0);
                default:   m_ready <= (rx_tick % 32 >= 24);
            endcase
        end
    end

    // ---------------- monitor ----------------

    always @(posedge aclk) begin : score
        scan_answer_t want;
        if (aresetn) begin
            if (s_valid && s_ready) advance_finder(s_func, s_element_value);
            if (m_valid && m_ready) begin
                n_results++;
                if (m_found === 1'b1) n_found++;
                if (answer_q.size() == 0) begin
                    $error("result transfer with no fetch outstanding: found=%0b row=%0d col=%0d",
                           m_found, m_match_row, m_match_col);
                    fail_count++;
                end else begin
                    want = answer_q.pop_front();
                    check_field("found", VALUE_W'(want.found), VALUE_W'(m_found));
                    check_field("match_row", VALUE_W'(want.row), VALUE_W'(m_match_row));
                    check_field("match_col", VALUE_W'(want.col), VALUE_W'(m_match_col));
                    check_field("match_value", want.value, m_match_value);
                    check_field("done_res", VALUE_W'(want.done), VALUE_W'(m_done_res));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d answers outstanding",
                     cycle_count, answer_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin : sequence_main
        int                 base;
        int                 phase;
        int                 nr;
        int                 nc;
        int                 fetches;
        logic [CFG_W-1:0]   big;
        logic [CFG_W-1:0]   narrow;
        logic [CFG_W-1:0]   raw_r;
        logic [CFG_W-1:0]   raw_c;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // lone cell: a nonzero value never equals its empty neighbourhood
        push_load(32'h7FFF_FFFF);
        push_fetch();
        push_fetch();
        push_load(32'h8000_0000);
        push_fetch();
        // lone zero cell matches, then the scan is spent
        push_load('0);
        push_fetch();
        push_fetch();

        set_counts(CFG_W'(2), CFG_W'(3));
        grid[0][0] = 32'h7FFF_FFFF;
        grid[0][1] = 32'h8000_0000;
        grid[0][2] = 32'h0000_0000;
        grid[1][0] = 32'hFFFF_FFFF;
        grid[1][1] = 32'h0001_0000;
        plant_cell(1, 2, 2, 3);    // match on the last cell, done stays low there
        load_grid(2, 3);
        repeat (3) push_fetch();

        // zero rows acts as one row; third load runs past the 1x2 matrix
        set_counts('0, CFG_W'(2));
        push_load('0);
        push_load(32'hFFFF_FFFF);
        push_load(32'h1234_5678);
        push_fetch();
        // load after fetch restarts at cell 0; cell 1 keeps the old value
        push_load(32'hFFFF_FFFF);
        push_fetch();
        push_fetch();

        base  = queued;
        phase = 0;
        while (queued < base + RANDOM_ITEMS) begin
            if (phase == 0) begin
                set_counts(CFG_W'(127), CFG_W'(1));
            end else if (phase == 1) begin
                set_counts(CFG_W'(1), CFG_W'(64));
            end else if ($urandom_range(0, 2) == 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    big    = CFG_W'($urandom_range(64, 127));
                    narrow = CFG_W'($urandom_range(1, 3));
                    if ($urandom_range(0, 1) == 0) set_counts(big, narrow);
                    else set_counts(narrow, big);
                end else begin
                    nr    = $urandom_range(1, 6);
                    nc    = $urandom_range(1, 6);
                    raw_r = (nr == 1 && $urandom_range(0, 1) == 0) ? '0 : CFG_W'(nr);
                    raw_c = (nc == 1 && $urandom_range(0, 1) == 0) ? '0 : CFG_W'(nc);
                    set_counts(raw_r, raw_c);
                end
            end
            phase++;

            if ($urandom_range(0, 9) < 7) begin
                fill_grid(gen_rows, gen_cols, fill_style_t'($urandom_range(0, 3)));
                load_grid(gen_rows, gen_cols);
                if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) push_load($urandom());
                // hold the sender until all answers are back
                if ($urandom_range(0, 5) == 0) wait_idle();
                if (gen_rows * gen_cols <= 20 && $urandom_range(0, 1) == 0)
                    fetches = gen_rows * gen_cols + 1;
                else
                    fetches = $urandom_range(1, 6);
                repeat (fetches) push_fetch();
            end else begin
                repeat ($urandom_range(3, 12)) begin
                    if ($urandom_range(0, 1) == 0)
                        push_load(pick_value(fill_style_t'($urandom_range(0, 3))));
                    else
                        push_fetch();
                end
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (answer_q.size() != 0) begin
            $error("%0d expected answers never arrived", answer_q.size());
            fail_count++;
        end

        $display("Covered %0d loads and %0d fetches over %0d count settings, clamped ones included.",
                 n_loads, n_fetches, n_settings);
        $display("Checked %0d scan answers, %0d of them reporting a matching cell.",
                 n_results, n_found);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
